// ----- sv/http_get_target_parser_unit_assert.svh -----
// Assertion macros shared by the HTTP GET target parser RTL.
`ifndef HTTP_GET_TARGET_PARSER_UNIT_ASSERT_SVH
`define HTTP_GET_TARGET_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HGTP_ASSERT_IMPL(name, clk_s, rst_ns, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HGTP_ASSERT_NEXT(name, clk_s, rst_ns, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hgtp_pkg.sv -----
// Shared types, codes and character tables of the HTTP GET target parser.
package hgtp_pkg;

  localparam int HOST_CAP_W = 11;
  localparam int PATH_CAP_W = 13;
  localparam logic [HOST_CAP_W-1:0] HOST_CAP_RST = 11'd256;
  localparam logic [PATH_CAP_W-1:0] PATH_CAP_RST = 13'd1024;
  localparam int TARGET_LIMIT_DEF = 1024;

  localparam int MAX_RES = 7;
  localparam int CNT_W   = 3;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes (word address bit above the byte offset)
  localparam logic REG_HOST_CAP = 1'b0;
  localparam logic REG_PATH_CAP = 1'b1;

  // Parse phases
  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_METHOD    = 4'd0;
  localparam logic [PH_W-1:0] PH_PREFIX    = 4'd1;
  localparam logic [PH_W-1:0] PH_HOST      = 4'd2;
  localparam logic [PH_W-1:0] PH_ABS_PATH  = 4'd3;
  localparam logic [PH_W-1:0] PH_REL_PATH  = 4'd4;
  localparam logic [PH_W-1:0] PH_ABS_REST  = 4'd5;
  localparam logic [PH_W-1:0] PH_REL_REST  = 4'd6;
  localparam logic [PH_W-1:0] PH_HDR_NAME  = 4'd7;
  localparam logic [PH_W-1:0] PH_HDR_SKIP  = 4'd8;
  localparam logic [PH_W-1:0] PH_HDR_BLANK = 4'd9;
  localparam logic [PH_W-1:0] PH_HDR_VALUE = 4'd10;
  localparam logic [PH_W-1:0] PH_DONE      = 4'd11;

  // Result kinds
  localparam logic [1:0] KIND_HOST   = 2'd0;
  localparam logic [1:0] KIND_PATH   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic [PH_W-1:0]       phase;
    logic [2:0]            prefix_idx;
    logic [HOST_CAP_W-1:0] host_len;
    logic [PATH_CAP_W-1:0] path_len;
    logic [2:0]            hdr_idx;
    logic                  cr_held;
  } pst_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    item_t [MAX_RES-1:0] items;
    logic  [CNT_W-1:0]   cnt;
  } grp_t;

  function automatic pst_t idle_state();
    pst_t s;
    s = '0;
    s.phase = PH_METHOD;
    return s;
  endfunction

  function automatic logic [7:0] method_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "G";
      3'd1:    c = "E";
      3'd2:    c = "T";
      3'd3:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] scheme_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "h";
      3'd1:    c = "t";
      3'd2:    c = "t";
      3'd3:    c = "p";
      3'd4:    c = ":";
      3'd5:    c = "/";
      3'd6:    c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] header_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "h";
      3'd1:    c = "o";
      3'd2:    c = "s";
      3'd3:    c = "t";
      3'd4:    c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

endpackage

// ----- sv/hgtp_step.sv -----
// Per-byte parse step: next parse state and the group of results one byte causes.
module hgtp_step #(
  parameter  int TARGET_LIMIT = hgtp_pkg::TARGET_LIMIT_DEF,
  localparam int TLEN_W       = $clog2(TARGET_LIMIT + 1)
) (
  input  hgtp_pkg::pst_t                      st_i,
  input  logic [TLEN_W-1:0]                   tlen_i,
  input  logic [hgtp_pkg::HOST_CAP_W-1:0]     host_cap_i,
  input  logic [hgtp_pkg::PATH_CAP_W-1:0]     path_cap_i,
  input  logic [7:0]                          byte_i,
  input  logic                                last_i,
  output hgtp_pkg::pst_t                      st_o,
  output logic [TLEN_W-1:0]                   tlen_o,
  output hgtp_pkg::grp_t                      grp_o
);

  localparam int HCW   = hgtp_pkg::HOST_CAP_W;
  localparam int PCW   = hgtp_pkg::PATH_CAP_W;
  localparam int HL1_W = HCW + 1;
  localparam int PL1_W = PCW + 1;
  localparam int CNT_W = hgtp_pkg::CNT_W;

  typedef struct packed {
    hgtp_pkg::pst_t    st;
    logic [TLEN_W-1:0] tlen;
    hgtp_pkg::grp_t    grp;
  } work_t;

  function automatic work_t put_item(work_t w, logic [1:0] k, logic [7:0] d);
    work_t r;
    r = w;
    if (r.grp.cnt < CNT_W'(hgtp_pkg::MAX_RES)) begin
      r.grp.items[r.grp.cnt].kind = k;
      r.grp.items[r.grp.cnt].data = d;
      r.grp.cnt = r.grp.cnt + 1'b1;
    end
    return r;
  endfunction

  // A rejection drops whatever this byte already produced.
  function automatic work_t decide(work_t w, logic ok);
    work_t r;
    r = w;
    if (r.st.phase != hgtp_pkg::PH_DONE) begin
      if (!ok) begin
        r.grp.cnt = '0;
      end
      r = put_item(r, ok ? hgtp_pkg::KIND_ACCEPT : hgtp_pkg::KIND_REJECT, 8'h00);
      r.st.phase   = hgtp_pkg::PH_DONE;
      r.st.cr_held = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t emit_host(work_t w, logic [7:0] b, logic [HCW-1:0] hcap);
    work_t r;
    r = w;
    if (({1'b0, r.st.host_len} + HL1_W'(1)) >= {1'b0, hcap}) begin
      r = decide(r, 1'b0);
    end else begin
      r.st.host_len = r.st.host_len + 1'b1;
      r = put_item(r, hgtp_pkg::KIND_HOST, b);
    end
    return r;
  endfunction

  function automatic work_t emit_path(work_t w, logic [7:0] b, logic [PCW-1:0] pcap);
    work_t r;
    r = w;
    if (({1'b0, r.st.path_len} + PL1_W'(1)) >= {1'b0, pcap}) begin
      r = decide(r, 1'b0);
    end else begin
      r.st.path_len = r.st.path_len + 1'b1;
      r = put_item(r, hgtp_pkg::KIND_PATH, b);
    end
    return r;
  endfunction

  function automatic work_t count_target(work_t w);
    work_t r;
    r = w;
    r.tlen = r.tlen + 1'b1;
    if (r.tlen >= TLEN_W'(TARGET_LIMIT)) begin
      r = decide(r, 1'b0);
    end
    return r;
  endfunction

  // Byte inside the target once the scheme question is settled.
  function automatic work_t path_byte(work_t w, logic [7:0] b, logic [PCW-1:0] pcap);
    work_t r;
    r = w;
    if (b == hgtp_pkg::CH_SPACE) begin
      r.st.phase = (r.st.phase == hgtp_pkg::PH_ABS_PATH) ? hgtp_pkg::PH_ABS_REST
                                                         : hgtp_pkg::PH_REL_REST;
    end else begin
      r = count_target(r);
      if (r.st.phase != hgtp_pkg::PH_DONE) begin
        r = emit_path(r, b, pcap);
      end
    end
    return r;
  endfunction

  function automatic work_t plain(work_t w, logic [7:0] b, logic [HCW-1:0] hcap,
                                 logic [PCW-1:0] pcap);
    work_t            r;
    logic [PL1_W-1:0] flush_end;
    r = w;
    flush_end = {1'b0, r.st.path_len} + PL1_W'(r.st.prefix_idx);
    unique case (r.st.phase) inside
      hgtp_pkg::PH_METHOD: begin
        if (r.st.prefix_idx < 3'd4 && b == hgtp_pkg::method_char(r.st.prefix_idx)) begin
          r.st.prefix_idx = r.st.prefix_idx + 1'b1;
          if (r.st.prefix_idx == 3'd4) begin
            r.st.phase      = hgtp_pkg::PH_PREFIX;
            r.st.prefix_idx = '0;
            r.tlen          = '0;
          end
        end else begin
          r = decide(r, 1'b0);
        end
      end
      hgtp_pkg::PH_PREFIX: begin
        if (r.st.prefix_idx < 3'd7 && b == hgtp_pkg::scheme_char(r.st.prefix_idx)) begin
          r = count_target(r);
          if (r.st.phase != hgtp_pkg::PH_DONE) begin
            r.st.prefix_idx = r.st.prefix_idx + 1'b1;
            if (r.st.prefix_idx == 3'd7) begin
              r.st.phase = hgtp_pkg::PH_HOST;
            end
          end
        end else if (b == hgtp_pkg::CH_SPACE && r.tlen == '0) begin
          r = decide(r, 1'b0);
        end else if (r.st.prefix_idx != '0 && flush_end >= {1'b0, pcap}) begin
          // flushing the held prefix would overrun the path capacity
          r = decide(r, 1'b0);
        end else begin
          for (int i = 0; i < hgtp_pkg::MAX_RES - 1; i++) begin
            if (3'(i) < r.st.prefix_idx) begin
              r = put_item(r, hgtp_pkg::KIND_PATH, hgtp_pkg::scheme_char(3'(i)));
            end
          end
          r.st.path_len   = r.st.path_len + PCW'(r.st.prefix_idx);
          r.st.prefix_idx = '0;
          r.st.phase      = hgtp_pkg::PH_REL_PATH;
          r = path_byte(r, b, pcap);
        end
      end
      hgtp_pkg::PH_HOST: begin
        if (b == hgtp_pkg::CH_SPACE) begin
          r = decide(r, 1'b0);
        end else begin
          r = count_target(r);
          if (r.st.phase != hgtp_pkg::PH_DONE) begin
            if (b == hgtp_pkg::CH_SLASH) begin
              if (r.st.host_len == '0) begin
                r = decide(r, 1'b0);
              end else begin
                r.st.phase = hgtp_pkg::PH_ABS_PATH;
                r = emit_path(r, b, pcap);
              end
            end else begin
              r = emit_host(r, b, hcap);
            end
          end
        end
      end
      hgtp_pkg::PH_ABS_PATH, hgtp_pkg::PH_REL_PATH: begin
        r = path_byte(r, b, pcap);
      end
      hgtp_pkg::PH_HDR_NAME: begin
        if (r.st.hdr_idx < 3'd5 &&
            hgtp_pkg::to_lower(b) == hgtp_pkg::header_char(r.st.hdr_idx)) begin
          r.st.hdr_idx = r.st.hdr_idx + 1'b1;
          if (r.st.hdr_idx == 3'd5) begin
            r.st.phase = hgtp_pkg::PH_HDR_BLANK;
          end
        end else begin
          r.st.hdr_idx = '0;
          r.st.phase   = hgtp_pkg::PH_HDR_SKIP;
        end
      end
      hgtp_pkg::PH_HDR_BLANK: begin
        if (b != hgtp_pkg::CH_SPACE && b != hgtp_pkg::CH_TAB) begin
          r.st.phase = hgtp_pkg::PH_HDR_VALUE;
          r = emit_host(r, b, hcap);
        end
      end
      hgtp_pkg::PH_HDR_VALUE: begin
        r = emit_host(r, b, hcap);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic work_t line_end(work_t w);
    work_t r;
    r = w;
    unique case (r.st.phase) inside
      hgtp_pkg::PH_ABS_REST: r = decide(r, 1'b1);
      hgtp_pkg::PH_REL_REST, hgtp_pkg::PH_HDR_SKIP: begin
        r.st.phase   = hgtp_pkg::PH_HDR_NAME;
        r.st.hdr_idx = '0;
      end
      hgtp_pkg::PH_HDR_NAME: begin
        if (r.st.hdr_idx == '0) begin
          r = decide(r, 1'b0);
        end else begin
          r.st.hdr_idx = '0;
        end
      end
      hgtp_pkg::PH_HDR_VALUE: r = decide(r, r.st.host_len != '0);
      hgtp_pkg::PH_DONE: begin
      end
      default: r = decide(r, 1'b0);
    endcase
    return r;
  endfunction

  function automatic work_t run_step(hgtp_pkg::pst_t st, logic [TLEN_W-1:0] tlen,
                                     logic [7:0] b, logic last,
                                     logic [HCW-1:0] hcap, logic [PCW-1:0] pcap);
    work_t r;
    r.st   = st;
    r.tlen = tlen;
    r.grp  = '0;
    if (r.st.phase != hgtp_pkg::PH_DONE) begin
      if (r.st.phase == hgtp_pkg::PH_METHOD) begin
        r = plain(r, b, hcap, pcap);
      end else if (r.st.cr_held) begin
        r.st.cr_held = 1'b0;
        if (b == hgtp_pkg::CH_LF) begin
          r = line_end(r);
        end else begin
          // a lone CR is an ordinary byte of the line
          r = plain(r, hgtp_pkg::CH_CR, hcap, pcap);
          if (r.st.phase != hgtp_pkg::PH_DONE) begin
            if (b == hgtp_pkg::CH_CR) begin
              r.st.cr_held = 1'b1;
            end else begin
              r = plain(r, b, hcap, pcap);
            end
          end
        end
      end else if (b == hgtp_pkg::CH_CR) begin
        r.st.cr_held = 1'b1;
      end else begin
        r = plain(r, b, hcap, pcap);
      end
    end
    if (last) begin
      r = decide(r, 1'b0);
      r.st   = hgtp_pkg::idle_state();
      r.tlen = '0;
    end
    return r;
  endfunction

  work_t res;

  assign res    = run_step(st_i, tlen_i, byte_i, last_i, host_cap_i, path_cap_i);
  assign st_o   = res.st;
  assign tlen_o = res.tlen;
  assign grp_o  = res.grp;

endmodule

// ----- sv/http_get_target_parser_unit.sv -----
// Top level of the HTTP GET request-target parser with its result buffer and APB registers.
//
//   Channel  | Dir | Handshake              | Payload
//   in_      | in  | in_valid / in_stall    | in_request_byte, in_end_of_request
//   out_     | out | out_valid / out_stall  | out_item_kind, out_item_byte, out_run_last
//   APB      | in  | psel, penable, pwrite  | paddr, pwdata -> prdata, pready (always 1)
//
// A request byte is parsed in the cycle it is accepted; its results (zero to seven) are stored
// in a group buffer register and shift into the output register one per cycle unless out_stall
// holds it. Bytes that cause no result or one result sustain one transaction per cycle while
// out_stall is low; a byte with more results stalls the input while the group buffer drains.
// rst_n (synchronous, active low) restores capacities 256 and 1024 and the idle parse state.
// out_stall holds the output register; the input stalls only while the group buffer still
// owes results beyond the one that leaves in this cycle.
`include "http_get_target_parser_unit_assert.svh"

module http_get_target_parser_unit #(
  parameter int TARGET_LIMIT = hgtp_pkg::TARGET_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request byte stream
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_request_byte,
  input  logic                         in_end_of_request,
  // result stream
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_item_kind,
  output logic [7:0]                   out_item_byte,
  output logic                         out_run_last,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hgtp_pkg::PADDR_W-1:0] paddr,
  input  logic [hgtp_pkg::PDATA_W-1:0] pwdata,
  output logic [hgtp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int TLEN_W  = $clog2(TARGET_LIMIT + 1);
  localparam int HCW     = hgtp_pkg::HOST_CAP_W;
  localparam int PCW     = hgtp_pkg::PATH_CAP_W;
  localparam int CNT_W   = hgtp_pkg::CNT_W;
  localparam int MAX_RES = hgtp_pkg::MAX_RES;
  localparam int PDW     = hgtp_pkg::PDATA_W;
  localparam int PAW     = hgtp_pkg::PADDR_W;

  // Parse state and configuration
  hgtp_pkg::pst_t     st_r, st_nxt, st_step;
  logic [TLEN_W-1:0]  tlen_r, tlen_nxt, tlen_step;
  logic [HCW-1:0]     host_cap_r, host_cap_nxt;
  logic [PCW-1:0]     path_cap_r, path_cap_nxt;

  // Result group buffer (head at index 0) and output register
  hgtp_pkg::grp_t                grp_step;
  hgtp_pkg::item_t [MAX_RES-1:0] grp_items_r, grp_items_nxt;
  logic [CNT_W-1:0]              grp_cnt_r, grp_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  hgtp_pkg::item_t               out_item_r, out_item_nxt;
  logic                          out_last_r, out_last_nxt;

  logic in_accept;
  logic out_free;
  logic grp_move;
  logic cfg_wr;
  logic cfg_idx;

  hgtp_step #(
    .TARGET_LIMIT (TARGET_LIMIT)
  ) u_step (
    .st_i       (st_r),
    .tlen_i     (tlen_r),
    .host_cap_i (host_cap_r),
    .path_cap_i (path_cap_r),
    .byte_i     (in_request_byte),
    .last_i     (in_end_of_request),
    .st_o       (st_step),
    .tlen_o     (tlen_step),
    .grp_o      (grp_step)
  );

  // Handshake: the output register is free when empty or drained this cycle; the
  // group buffer can take a new byte's results once its last entry is leaving.
  assign out_free  = !out_valid_r || !out_stall;
  assign grp_move  = (grp_cnt_r != '0) && out_free;
  assign in_stall  = (grp_cnt_r > CNT_W'(1)) || ((grp_cnt_r == CNT_W'(1)) && !out_free);
  assign in_accept = in_valid && !in_stall;

  // Advance parse state only on an accepted transaction
  always_comb begin
    st_nxt   = st_r;
    tlen_nxt = tlen_r;
    if (in_accept) begin
      st_nxt   = st_step;
      tlen_nxt = tlen_step;
    end
  end

  // Load a fresh group, or shift the buffer down as its head moves out
  always_comb begin
    grp_items_nxt = grp_items_r;
    grp_cnt_nxt   = grp_cnt_r;
    if (in_accept) begin
      grp_items_nxt = grp_step.items;
      grp_cnt_nxt   = grp_step.cnt;
    end else if (grp_move) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        grp_items_nxt[i] = grp_items_r[i + 1];
      end
      grp_cnt_nxt = grp_cnt_r - 1'b1;
    end
  end

  // Output register: take the group head, else drop the transaction once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    out_last_nxt  = out_last_r;
    if (grp_move) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = grp_items_r[0];
      out_last_nxt  = (grp_cnt_r == CNT_W'(1));
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // APB register file: word index sits above the byte offset
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[PAW-1];
  assign pready  = 1'b1;

  always_comb begin
    host_cap_nxt = host_cap_r;
    path_cap_nxt = path_cap_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        hgtp_pkg::REG_HOST_CAP: host_cap_nxt = pwdata[HCW-1:0];
        hgtp_pkg::REG_PATH_CAP: path_cap_nxt = pwdata[PCW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PAW-2:0] == '0) begin
      unique case (cfg_idx)
        hgtp_pkg::REG_HOST_CAP: prdata = PDW'(host_cap_r);
        hgtp_pkg::REG_PATH_CAP: prdata = PDW'(path_cap_r);
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= hgtp_pkg::idle_state();
      tlen_r      <= '0;
      host_cap_r  <= hgtp_pkg::HOST_CAP_RST;
      path_cap_r  <= hgtp_pkg::PATH_CAP_RST;
      grp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      tlen_r      <= tlen_nxt;
      host_cap_r  <= host_cap_nxt;
      path_cap_r  <= path_cap_nxt;
      grp_cnt_r   <= grp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    grp_items_r <= grp_items_nxt;
    out_item_r  <= out_item_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_item_kind = out_item_r.kind;
  assign out_item_byte = out_item_r.data;
  assign out_run_last  = out_last_r;

  // Assertions

  // The final byte of a request always leaves the parser idle for the next one
  `HGTP_ASSERT_NEXT(a_eor_idles, clk, rst_n, in_accept && in_end_of_request, st_r.phase == hgtp_pkg::PH_METHOD && !st_r.cr_held && tlen_r == '0, "request end did not idle the parser")
  // A rejection replaces everything its byte produced, so it closes its group
  `HGTP_ASSERT_IMPL(a_reject_alone, clk, rst_n, out_valid_r && out_item_r.kind == hgtp_pkg::KIND_REJECT, out_last_r, "reject status not alone in its group")
  // Once decided, further bytes of the request produce nothing
  `HGTP_ASSERT_NEXT(a_done_silent, clk, rst_n, in_accept && st_r.phase == hgtp_pkg::PH_DONE, grp_cnt_r == '0, "results after the request was decided")
  // A decided request never holds a carriage return
  `HGTP_ASSERT_IMPL(a_done_no_cr, clk, rst_n, st_r.phase == hgtp_pkg::PH_DONE, !st_r.cr_held, "carriage return held after decision")

endmodule
